>>> src/pfdrc_pkg.sv
// Shared types and codes for the packet queue with duplicate refusal and range count.
package pfdrc_pkg;

  localparam int unsigned SrcW   = 16;
  localparam int unsigned DstW   = 16;
  localparam int unsigned TsW    = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned LimitW = 7;
  localparam int unsigned CountW = 7;
  localparam logic [LimitW-1:0] LimitReset = 7'd64;

  typedef enum logic [KindW-1:0] {
    KIND_ADD     = 2'd0,
    KIND_FORWARD = 2'd1,
    KIND_COUNT   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [SrcW-1:0] src;
    logic [DstW-1:0] dst;
    logic [TsW-1:0]  ts;
  } pkt_t;

  typedef struct packed {
    pkt_t           pkt;
    logic [TsW-1:0] lo;
    logic [TsW-1:0] hi;
  } req_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

>>> src/pfdrc_cell.sv
// One queue slot: holds a packet, shifts toward the head, compares against the request.
module pfdrc_cell (
  input  logic              clk,
  input  logic              rst,
  input  pfdrc_pkg::cell_ctrl_t ctrl,
  input  pfdrc_pkg::req_t   req,
  input  pfdrc_pkg::pkt_t   nb_pkt,
  input  logic              nb_valid,
  output pfdrc_pkg::pkt_t   pkt,
  output logic              valid,
  output logic              dup_hit,
  output logic              cnt_hit
);
  import pfdrc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end else if (ctrl.shift) begin
      valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pkt <= req.pkt;
    end else if (ctrl.shift) begin
      pkt <= nb_pkt;
    end
  end

  // register per-slot hits; the request is stable for the compare cycle
  always_ff @(posedge clk) begin
    dup_hit <= valid && (pkt == req.pkt);
    cnt_hit <= valid && (pkt.dst == req.pkt.dst) &&
               (pkt.ts >= req.lo) && (pkt.ts <= req.hi);
  end

endmodule

>>> src/pfdrc_count.sv
// Adder tree that counts the set bits of the per-slot hit vector.
module pfdrc_count #(
  parameter int unsigned N = 64
) (
  input  logic [N-1:0]           bits,
  output logic [$clog2(N+1)-1:0] total
);
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned L  = $clog2(N);
  localparam int unsigned P  = 1 << L;

  logic [CW-1:0] sums [0:L][0:P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_bit
      assign sums[0][j] = CW'(bits[j]);
    end else begin : g_pad
      assign sums[0][j] = '0;
    end
  end

  for (genvar l = 0; l < L; l++) begin : g_lvl
    for (genvar j = 0; j < P; j++) begin : g_node
      if (j < (P >> (l + 1))) begin : g_add
        assign sums[l+1][j] = sums[l][2*j] + sums[l][2*j+1];
      end else begin : g_zero
        assign sums[l+1][j] = '0;
      end
    end
  end

  assign total = sums[L][0];

endmodule

>>> src/packet_fifo_dedup_range_count.sv
// Top level: bounded packet queue with duplicate refusal, eviction and range count.
//
// Usage: pulse start with kind and the request fields while busy is low; the
// request is taken at that edge. Kind add appends a packet unless an identical
// one is queued (evicting the oldest when occupancy reaches memory_limit),
// forward pops the oldest packet, count reports queued packets whose
// destination matches and whose timestamp lies in [start_time, end_time].
// Every request, an unused kind included, yields one result transfer: done is
// high for exactly one cycle with all result fields; the receiver cannot stall
// and fields that do not apply read zero.
// A request passes the compare state and then the apply state; its result is
// registered from the apply state. busy is high only in the compare cycle, and a
// new request may be taken in the cycle that applies the previous one.
// Queue slots form a chain of cells, oldest at cell 0; each cycle a cell keeps
// its packet, loads the new one or takes its neighbor's on a pop. The compare
// cycle registers per-cell hits; the apply cycle ORs and adds them up.
// memory_limit sits at APB address 0 (reset 64, zero acts as one, values above
// DEPTH act as DEPTH); write it only while no request is in flight.
// Reset empties the queue at once; no clearing pass is needed.
module packet_fifo_dedup_range_count #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [pfdrc_pkg::KindW-1:0] kind,
  input  logic [pfdrc_pkg::SrcW-1:0]  source,
  input  logic [pfdrc_pkg::DstW-1:0]  destination,
  input  logic [pfdrc_pkg::TsW-1:0]   timestamp,
  input  logic [pfdrc_pkg::TsW-1:0]   start_time,
  input  logic [pfdrc_pkg::TsW-1:0]   end_time,
  output logic                       done,
  output logic                       accepted,
  output logic                       has_packet,
  output logic [pfdrc_pkg::SrcW-1:0]  out_source,
  output logic [pfdrc_pkg::DstW-1:0]  out_destination,
  output logic [pfdrc_pkg::TsW-1:0]   out_timestamp,
  output logic [pfdrc_pkg::CountW-1:0] match_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pfdrc_pkg::*;

  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (OW > LimitW) ? OW : LimitW;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  state_t state;
  logic   take;

  // config register
  logic [LimitW-1:0] memory_limit;
  logic              cfg_wr;

  // latched request
  kind_t req_kind;
  req_t  req;

  // queue chain
  logic [OW-1:0] occupancy;
  logic [OW-1:0] occupancy_next;
  cell_ctrl_t    ctrl [DEPTH];
  pkt_t          cell_pkt [DEPTH+1];
  logic [DEPTH:0] cell_valid;
  logic [DEPTH-1:0] dup_hits;
  logic [DEPTH-1:0] cnt_hits;
  logic [CW-1:0]    hit_total;

  // apply-cycle decisions
  logic [LW-1:0] eff_limit;
  logic          dup;
  logic          add_ok;
  logic          pop_add;
  logic          fwd_ok;
  logic          shift;
  logic [OW-1:0] wpos;
  logic          exec;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_limit <= LimitReset;
    end else if (cfg_wr) begin
      memory_limit <= pwdata[LimitW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'b0) begin
      prdata = 32'(memory_limit);
    end
  end

  assign busy = (state == ST_CMP);
  assign take = start && !busy;
  assign exec = (state == ST_EXEC);

  always_ff @(posedge clk) begin
    if (take) begin
      req_kind   <= kind_t'(kind);
      req.pkt.src <= source;
      req.pkt.dst <= destination;
      req.pkt.ts  <= timestamp;
      req.lo      <= start_time;
      req.hi      <= end_time;
    end
  end

  // clamp the limit into [1, DEPTH]
  always_comb begin
    eff_limit = LW'(memory_limit);
    if (memory_limit == '0) begin
      eff_limit = LW'(1);
    end else if (LW'(memory_limit) > LW'(DEPTH)) begin
      eff_limit = LW'(DEPTH);
    end
  end

  always_comb begin
    dup     = |dup_hits;
    add_ok  = exec && (req_kind == KIND_ADD) && !dup;
    pop_add = add_ok && (LW'(occupancy) >= eff_limit);
    fwd_ok  = exec && (req_kind == KIND_FORWARD) && (occupancy != '0);
    shift   = pop_add || fwd_ok;
    wpos    = pop_add ? (occupancy - OW'(1)) : occupancy;
    occupancy_next = occupancy;
    if (add_ok && !pop_add) begin
      occupancy_next = occupancy + OW'(1);
    end else if (fwd_ok) begin
      occupancy_next = occupancy - OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  // the slot past the tail feeds an empty packet into the chain
  assign cell_pkt[DEPTH]   = '0;
  assign cell_valid[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].shift = shift;
    assign ctrl[i].load  = add_ok && (wpos == OW'(i));

    pfdrc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[i]),
      .req      (req),
      .nb_pkt   (cell_pkt[i+1]),
      .nb_valid (cell_valid[i+1]),
      .pkt      (cell_pkt[i]),
      .valid    (cell_valid[i]),
      .dup_hit  (dup_hits[i]),
      .cnt_hit  (cnt_hits[i])
    );
  end

  pfdrc_count #(.N(DEPTH)) u_count (
    .bits  (cnt_hits),
    .total (hit_total)
  );

  // state and registered result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      done            <= 1'b0;
      accepted        <= 1'b0;
      has_packet      <= 1'b0;
      out_source      <= '0;
      out_destination <= '0;
      out_timestamp   <= '0;
      match_count     <= '0;
    end else begin
      done <= exec;
      case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= take ? ST_CMP : ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (exec) begin
        accepted        <= add_ok;
        has_packet      <= fwd_ok;
        out_source      <= fwd_ok ? cell_pkt[0].src : '0;
        out_destination <= fwd_ok ? cell_pkt[0].dst : '0;
        out_timestamp   <= fwd_ok ? cell_pkt[0].ts : '0;
        match_count     <= (req_kind == KIND_COUNT) ?
                           CountW'(hit_total) : '0;
      end
    end
  end

endmodule
